>>> sv/lobm_pkg.sv
// shared constants and types for the limit order book matcher
package lobm_pkg;
  localparam int BOOK_DEPTH = 32;
  localparam int IDX_W = $clog2(BOOK_DEPTH);
  localparam int CNT_W = $clog2(BOOK_DEPTH + 1);

  localparam logic [1:0] OUT_FILLED  = 2'd0;
  localparam logic [1:0] OUT_RESTED  = 2'd1;
  localparam logic [1:0] OUT_DROPPED = 2'd2;
  localparam logic [1:0] OUT_REJECT  = 2'd3;

  typedef struct packed {
    logic             drop;
    logic             upd_front;
    logic [31:0]      new_qty;
    logic             insert;
    logic [IDX_W-1:0] ins_pos;
    logic [31:0]      ins_price;
    logic [31:0]      ins_qty;
    logic [31:0]      ins_id;
  } book_cmd_t;

  function automatic logic [31:0] price_key(input logic [31:0] p);
    price_key = p ^ 32'h8000_0000;
  endfunction
endpackage

>>> sv/lobm_book.sv
// one side of the book: sorted entries held in a shift line with count
module lobm_book (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lobm_pkg::book_cmd_t        cmd_i,
  input  logic [lobm_pkg::IDX_W-1:0] rd_idx_i,
  output logic [31:0]                front_price_o,
  output logic [31:0]                front_qty_o,
  output logic [31:0]                front_id_o,
  output logic [31:0]                rd_price_o,
  output logic [lobm_pkg::CNT_W-1:0] count_o
);
  import lobm_pkg::*;

  logic [31:0] price_q [BOOK_DEPTH];
  logic [31:0] qty_q   [BOOK_DEPTH];
  logic [31:0] id_q    [BOOK_DEPTH];
  logic [CNT_W-1:0] count_q;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < BOOK_DEPTH; k++) begin
      if (cmd_i.drop) begin
        if (k < BOOK_DEPTH - 1) begin
          price_q[k] <= price_q[k+1];
          qty_q[k]   <= qty_q[k+1];
          id_q[k]    <= id_q[k+1];
        end
      end else if (cmd_i.insert) begin
        if (IDX_W'(k) == cmd_i.ins_pos) begin
          price_q[k] <= cmd_i.ins_price;
          qty_q[k]   <= cmd_i.ins_qty;
          id_q[k]    <= cmd_i.ins_id;
        end else if (k > 0 && IDX_W'(k) > cmd_i.ins_pos) begin
          price_q[k] <= price_q[k-1];
          qty_q[k]   <= qty_q[k-1];
          id_q[k]    <= id_q[k-1];
        end
      end else if (cmd_i.upd_front && k == 0) begin
        qty_q[k] <= cmd_i.new_qty;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.drop) begin
      count_q <= count_q - CNT_W'(1);
    end else if (cmd_i.insert) begin
      count_q <= count_q + CNT_W'(1);
    end
  end

  assign front_price_o = price_q[0];
  assign front_qty_o   = qty_q[0];
  assign front_id_o    = id_q[0];
  assign rd_price_o    = price_q[rd_idx_i];
  assign count_o       = count_q;
endmodule

>>> sv/limit_order_book_matcher.sv
// limit order book matcher: sequencer, shared price compare and two books
// sequence: the match state issues the trades, then resolve, then an insert search over
//   the resting entries for a limit remainder, then one status record
// requests: one at a time, the next is taken only once the block is back in idle
// reset: asynchronous active low, both books empty, no results pending
// the receiver cannot stall; each result is shown for one cycle on valid_o
module limit_order_book_matcher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        side_i,
  input  logic        is_market_i,
  input  logic [31:0] order_id_i,
  input  logic [15:0] instrument_i,
  input  logic signed [31:0] limit_price_i,
  input  logic [31:0] quantity_i,
  output logic        valid_o,
  output logic        is_status_o,
  output logic [31:0] taker_id_o,
  output logic [31:0] maker_id_o,
  output logic [15:0] trade_instrument_o,
  output logic signed [31:0] trade_price_o,
  output logic [31:0] trade_quantity_o,
  output logic [31:0] leftover_quantity_o,
  output logic [1:0]  outcome_o,
  output logic        last_o
);
  import lobm_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_MATCH, S_RESOLVE, S_SEARCH, S_STATUS} state_e;

  state_e state_q;
  logic        side_q, mkt_q;
  logic [31:0] id_q, price_q, rem_q;
  logic [15:0] inst_q;
  logic [CNT_W-1:0] n_q;
  logic [IDX_W-1:0] widx_q;
  logic [1:0]  outc_q;

  // book ports
  book_cmd_t buy_cmd, sell_cmd, opp_cmd, own_cmd;
  logic [31:0] b_fp, b_fq, b_fi, b_rp, s_fp, s_fq, s_fi, s_rp;
  logic [CNT_W-1:0] b_cnt, s_cnt;

  lobm_book u_buy (
    .clk_i, .rst_ni, .cmd_i(buy_cmd), .rd_idx_i(widx_q),
    .front_price_o(b_fp), .front_qty_o(b_fq), .front_id_o(b_fi),
    .rd_price_o(b_rp), .count_o(b_cnt)
  );
  lobm_book u_sell (
    .clk_i, .rst_ni, .cmd_i(sell_cmd), .rd_idx_i(widx_q),
    .front_price_o(s_fp), .front_qty_o(s_fq), .front_id_o(s_fi),
    .rd_price_o(s_rp), .count_o(s_cnt)
  );

  // opposite book is matched, own book receives a remainder
  logic [31:0] opp_p, opp_q, opp_i, own_rp;
  logic [CNT_W-1:0] opp_cnt, own_cnt;
  assign opp_p   = side_q ? b_fp : s_fp;
  assign opp_q   = side_q ? b_fq : s_fq;
  assign opp_i   = side_q ? b_fi : s_fi;
  assign opp_cnt = side_q ? b_cnt : s_cnt;
  assign own_cnt = side_q ? s_cnt : b_cnt;
  assign own_rp  = side_q ? s_rp : b_rp;

  // shared key comparator: limit key against front or searched entry
  logic [31:0] cmp_a, cmp_b;
  logic cmp_lt, cmp_gt;
  assign cmp_a  = price_key(price_q);
  assign cmp_b  = price_key((state_q == S_MATCH) ? opp_p : own_rp);
  assign cmp_lt = cmp_a < cmp_b;
  assign cmp_gt = cmp_a > cmp_b;

  logic        can_match, crosses, keep_walk, at_end;
  logic [31:0] fill;
  assign can_match = (rem_q != '0) && (opp_cnt != '0) && (n_q != CNT_W'(BOOK_DEPTH));
  assign crosses   = mkt_q || (side_q ? !cmp_gt : !cmp_lt);
  assign fill      = (rem_q < opp_q) ? rem_q : opp_q;
  // buy book descends, sell book ascends; walk past equal or better prices
  assign keep_walk = side_q ? !cmp_lt : !cmp_gt;
  assign at_end    = {1'b0, widx_q} == own_cnt;

  always_comb begin
    opp_cmd = '0;
    own_cmd = '0;
    if (state_q == S_MATCH && can_match && crosses) begin
      opp_cmd.drop      = (opp_q == fill);
      opp_cmd.upd_front = (opp_q != fill);
      opp_cmd.new_qty   = opp_q - fill;
    end
    if (state_q == S_SEARCH && (at_end || !keep_walk)) begin
      own_cmd.insert    = 1'b1;
      own_cmd.ins_pos   = widx_q;
      own_cmd.ins_price = price_q;
      own_cmd.ins_qty   = rem_q;
      own_cmd.ins_id    = id_q;
    end
    buy_cmd  = side_q ? opp_cmd : own_cmd;
    sell_cmd = side_q ? own_cmd : opp_cmd;
  end

  assign busy = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_o <= 1'b0;
      n_q     <= '0;
      widx_q  <= '0;
    end else begin
      valid_o <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            side_q  <= side_i;
            mkt_q   <= is_market_i;
            id_q    <= order_id_i;
            inst_q  <= instrument_i;
            price_q <= limit_price_i;
            rem_q   <= quantity_i;
            n_q     <= '0;
            widx_q  <= '0;
            state_q <= S_MATCH;
          end
        end
        S_MATCH: begin
          if (can_match && crosses) begin
            // trade at the resting price
            valid_o             <= 1'b1;
            is_status_o         <= 1'b0;
            taker_id_o          <= id_q;
            maker_id_o          <= opp_i;
            trade_instrument_o  <= inst_q;
            trade_price_o       <= opp_p;
            trade_quantity_o    <= fill;
            leftover_quantity_o <= '0;
            outcome_o           <= OUT_FILLED;
            last_o              <= 1'b0;
            rem_q               <= rem_q - fill;
            n_q                 <= n_q + CNT_W'(1);
          end else begin
            state_q <= S_RESOLVE;
          end
        end
        S_RESOLVE: begin
          if (rem_q == '0) begin
            outc_q  <= OUT_FILLED;
            state_q <= S_STATUS;
          end else if (mkt_q) begin
            outc_q  <= OUT_DROPPED;
            state_q <= S_STATUS;
          end else if (own_cnt >= CNT_W'(BOOK_DEPTH)) begin
            outc_q  <= OUT_REJECT;
            state_q <= S_STATUS;
          end else begin
            widx_q  <= '0;
            state_q <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (at_end || !keep_walk) begin
            outc_q  <= OUT_RESTED;
            state_q <= S_STATUS;
          end else begin
            widx_q <= widx_q + IDX_W'(1);
          end
        end
        S_STATUS: begin
          valid_o             <= 1'b1;
          is_status_o         <= 1'b1;
          taker_id_o          <= id_q;
          maker_id_o          <= '0;
          trade_instrument_o  <= inst_q;
          trade_price_o       <= '0;
          trade_quantity_o    <= '0;
          leftover_quantity_o <= rem_q;
          outcome_o           <= outc_q;
          last_o              <= 1'b1;
          state_q             <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_last_is_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (last_o == is_status_o)) else $error("last flag mismatch");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_cnt <= CNT_W'(BOOK_DEPTH)) && (s_cnt <= CNT_W'(BOOK_DEPTH)))
    else $error("book count overflow");
  a_no_insert_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    own_cmd.insert |-> (own_cnt < CNT_W'(BOOK_DEPTH))) else $error("insert into full book");
  a_status_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_STATUS) |=> (valid_o && is_status_o && !busy))
    else $error("status not issued");
`endif
endmodule

>>> test/limit_order_book_matcher_tb.sv
// self-checking testbench for the limit order book matcher
module limit_order_book_matcher_tb;
  import lobm_pkg::*;

  // one output record, trade or status
  typedef struct packed {
    bit        is_status;
    bit [31:0] taker;
    bit [31:0] maker;
    bit [15:0] inst;
    bit [31:0] price;
    bit [31:0] fill_qty;
    bit [31:0] left_qty;
    bit [1:0]  outcome;
    bit        last;
  } fill_rec_t;

  // mirror of both books plus the queue of records still owed by the block
  class book_scoreboard;
    bit signed [31:0] bid_px[BOOK_DEPTH], ask_px[BOOK_DEPTH];
    bit [31:0]        bid_qty[BOOK_DEPTH], ask_qty[BOOK_DEPTH];
    bit [31:0]        bid_id[BOOK_DEPTH], ask_id[BOOK_DEPTH];
    int               bid_n, ask_n;
    fill_rec_t        owed_q[$];
    int               errors, records, trades, rejects, drops;

    function int pending();
      return owed_q.size();
    endfunction

    // match one accepted order and queue the records it must produce
    function void note_order(bit sell, bit mkt, bit [31:0] id, bit [15:0] inst,
                             bit signed [31:0] px, bit [31:0] qty);
      bit [31:0]        rem, fill;
      bit signed [31:0] best;
      bit [1:0]         oc;
      int               n, pos, k;
      fill_rec_t        r;
      rem = qty;
      n = 0;
      while (rem != 0 && (sell ? bid_n : ask_n) > 0 && n < BOOK_DEPTH) begin
        best = sell ? bid_px[0] : ask_px[0];
        if (!mkt && (sell ? (px > best) : (px < best))) break;
        fill = sell ? bid_qty[0] : ask_qty[0];
        if (rem < fill) fill = rem;
        r = '{1'b0, id, sell ? bid_id[0] : ask_id[0], inst, best, fill, 0, OUT_FILLED, 1'b0};
        owed_q.insert(owed_q.size(), r);
        n++;
        rem -= fill;
        if (sell) begin
          bid_qty[0] -= fill;
          if (bid_qty[0] == 0) begin
            for (k = 0; k < bid_n - 1; k++) begin
              bid_px[k] = bid_px[k+1]; bid_qty[k] = bid_qty[k+1]; bid_id[k] = bid_id[k+1];
            end
            bid_n--;
          end
        end else begin
          ask_qty[0] -= fill;
          if (ask_qty[0] == 0) begin
            for (k = 0; k < ask_n - 1; k++) begin
              ask_px[k] = ask_px[k+1]; ask_qty[k] = ask_qty[k+1]; ask_id[k] = ask_id[k+1];
            end
            ask_n--;
          end
        end
      end
      trades += n;
      if (rem == 0) oc = OUT_FILLED;
      else if (mkt) oc = OUT_DROPPED;
      else if ((sell ? ask_n : bid_n) >= BOOK_DEPTH) oc = OUT_REJECT;
      else begin
        oc = OUT_RESTED;
        // rest behind every entry of equal or better price
        if (sell) begin
          pos = 0;
          while (pos < ask_n && ask_px[pos] <= px) pos++;
          for (k = ask_n; k > pos; k--) begin
            ask_px[k] = ask_px[k-1]; ask_qty[k] = ask_qty[k-1]; ask_id[k] = ask_id[k-1];
          end
          ask_px[pos] = px; ask_qty[pos] = rem; ask_id[pos] = id;
          ask_n++;
        end else begin
          pos = 0;
          while (pos < bid_n && bid_px[pos] >= px) pos++;
          for (k = bid_n; k > pos; k--) begin
            bid_px[k] = bid_px[k-1]; bid_qty[k] = bid_qty[k-1]; bid_id[k] = bid_id[k-1];
          end
          bid_px[pos] = px; bid_qty[pos] = rem; bid_id[pos] = id;
          bid_n++;
        end
      end
      if (oc == OUT_REJECT) rejects++;
      if (oc == OUT_DROPPED) drops++;
      r = '{1'b1, id, 0, inst, 0, 0, rem, oc, 1'b1};
      owed_q.insert(owed_q.size(), r);
    endfunction

    // compare one observed record with the oldest one owed
    function void check_record(fill_rec_t got);
      fill_rec_t want;
      records++;
      if (owed_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: unexpected record taker=%h status=%0b", got.taker, got.is_status);
        return;
      end
      want = owed_q[0];
      owed_q.delete(0);
      if (got != want) begin
        errors++;
        if (errors <= 10) begin
          $display("ERROR: record mismatch");
          $display("  exp st=%0b tk=%h mk=%h in=%h px=%h q=%h lf=%h oc=%0d l=%0b",
                   want.is_status, want.taker, want.maker, want.inst, want.price,
                   want.fill_qty, want.left_qty, want.outcome, want.last);
          $display("  got st=%0b tk=%h mk=%h in=%h px=%h q=%h lf=%h oc=%0d l=%0b",
                   got.is_status, got.taker, got.maker, got.inst, got.price,
                   got.fill_qty, got.left_qty, got.outcome, got.last);
        end
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        side_i = 1'b0;
  logic        is_market_i = 1'b0;
  logic [31:0] order_id_i = '0;
  logic [15:0] instrument_i = '0;
  logic signed [31:0] limit_price_i = '0;
  logic [31:0] quantity_i = '0;
  logic        valid_o, is_status_o, last_o;
  logic [31:0] taker_id_o, maker_id_o, trade_quantity_o, leftover_quantity_o;
  logic [15:0] trade_instrument_o;
  logic signed [31:0] trade_price_o;
  logic [1:0]  outcome_o;

  book_scoreboard book_sb = new();
  int          idle_pct;     // chance in percent of a sender gap after each request
  int          n_orders;

  always #6 clk_i = ~clk_i;

  limit_order_book_matcher dut (
    .clk_i, .rst_ni, .start, .busy,
    .side_i, .is_market_i, .order_id_i, .instrument_i, .limit_price_i, .quantity_i,
    .valid_o, .is_status_o, .taker_id_o, .maker_id_o, .trade_instrument_o,
    .trade_price_o, .trade_quantity_o, .leftover_quantity_o, .outcome_o, .last_o
  );

  // result monitor: values read at the edge are the ones the edge samples
  always @(posedge clk_i) begin
    fill_rec_t r;
    if (rst_ni && valid_o) begin
      r = '{is_status_o, taker_id_o, maker_id_o, trade_instrument_o, trade_price_o,
            trade_quantity_o, leftover_quantity_o, outcome_o, last_o};
      book_sb.check_record(r);
    end
  end

  // drive one request, hold it until the block takes it, then maybe go idle
  task automatic send_order(bit sell, bit mkt, bit [31:0] id, bit [15:0] inst,
                            bit [31:0] px, bit [31:0] qty);
    start         <= 1'b1;
    side_i        <= sell;
    is_market_i   <= mkt;
    order_id_i    <= id;
    instrument_i  <= inst;
    limit_price_i <= px;
    quantity_i    <= qty;
    do @(posedge clk_i); while (busy !== 1'b0);
    book_sb.note_order(sell, mkt, id, inst, px, qty);
    n_orders++;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
  endtask

  // sender holds off until every owed record has shown up
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (book_sb.pending() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  // random order with content kept near a moving mid price so books cross
  task automatic random_order(int signed mid);
    bit        sell, mkt;
    bit [31:0] px, qty;
    int        pick;
    pick = $urandom_range(99);
    sell = 1'($urandom_range(1));
    mkt  = (pick < 8);
    px   = mid + $signed($urandom_range(10)) - 5;
    qty  = $urandom_range(1, 25);
    if (pick >= 8 && pick < 12) qty = 0;
    if (pick >= 12 && pick < 16) begin
      // noise: any field value at all
      px  = $urandom;
      qty = $urandom;
    end
    send_order(sell, mkt, $urandom, 16'($urandom), px, qty);
  endtask

  // fill one book to capacity with far-off prices, overflow it, then sweep it
  task automatic book_flood(bit sell);
    while ((sell ? book_sb.ask_n : book_sb.bid_n) < BOOK_DEPTH)
      send_order(sell, 1'b0, $urandom, 16'($urandom),
                 sell ? 32'h7fff_ffff : 32'h8000_0000, $urandom_range(1, 9));
    send_order(sell, 1'b0, $urandom, 16'($urandom),
               sell ? 32'h7fff_ffff : 32'h8000_0000, 5);   // book full
    send_order(!sell, 1'b1, $urandom, 16'($urandom), 0, 32'hffff_ffff);  // sweep all
  endtask

  initial begin
    int phase, i;
    int signed mid;
    idle_pct = 0;
    n_orders = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty book, zero quantity, extremes, fifo at one price, crossing
    send_order(0, 1, 32'h0000_0001, 16'h0000, 0, 10);                 // market into empty
    send_order(1, 0, 32'hffff_ffff, 16'hffff, 100, 0);                // zero quantity
    send_order(1, 0, 32'h0000_0010, 16'h1234, 32'h7fff_ffff, 32'hffff_ffff);
    send_order(0, 0, 32'h0000_0011, 16'h4321, 32'h8000_0000, 32'hffff_ffff);
    send_order(1, 0, 32'h0000_0020, 16'h0001, 50, 3);
    send_order(1, 0, 32'h0000_0021, 16'h0001, 50, 4);                 // same price, later
    send_order(1, 0, 32'h0000_0022, 16'h0001, 49, 2);                 // better price
    send_order(0, 0, 32'h0000_0030, 16'h0002, 48, 5);                 // below best, rests
    send_order(0, 0, 32'h0000_0031, 16'h0002, 50, 6);                 // crosses at equal
    send_order(0, 1, 32'h0000_0032, 16'h0003, 0, 100);                // market sweeps
    send_order(1, 0, 32'h0000_0040, 16'h0004, 48, 2);                 // sell at best bid
    send_order(1, 1, 32'h0000_0041, 16'h0005, 0, 32'hffff_ffff);      // market sell
    send_order(0, 0, 32'h0000_0050, 16'h0006, -7, 8);                 // negative prices
    send_order(1, 0, 32'h0000_0051, 16'h0006, -9, 3);
    send_order(0, 0, 32'h0000_0052, 16'h0006, -9, 1);
    drain();

    // random phases: back to back, mostly idle sender, rarely idle sender
    for (phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 1) ? 72 : (phase == 2) ? 6 : 0;
      mid = $signed($urandom_range(200)) - 100;
      if (phase < 2) book_flood(phase[0]);
      for (i = 0; i < 42; i++) begin
        if ($urandom_range(9) == 0) mid = mid + $signed($urandom_range(6)) - 3;
        random_order(mid);
      end
      drain();
    end

    $display("run covered %0d orders, %0d records, %0d trades, %0d rejects, %0d drops",
             n_orders, book_sb.records, book_sb.trades, book_sb.rejects, book_sb.drops);
    $display("mismatches: %0d", book_sb.errors);
    if (book_sb.errors == 0 && book_sb.pending() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // watchdog for a hung handshake or missing records
  initial begin
    #30000000;
    $display("timeout waiting on the block");
    $display("Regression FAIL");
    $finish;
  end

endmodule
